>>> hw/rtl/flc_pkg.sv
// Package for the frame local contrast block: register codes, field widths,
// controller types and the per-pixel contrast function.
// No dependencies.
package flc_pkg;

   localparam int PIXEL_W        = 8;
   localparam int TOTAL_W        = 31;
   localparam int MEAN_W         = 16;
   localparam int CFG_WIDTH_W    = 12;
   localparam int CFG_HEIGHT_W   = 13;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 13;
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int RESET_WIDTH    = 640;
   localparam int RESET_HEIGHT   = 480;
   // The dividend is (total << 8), so it carries eight more bits than the total.
   localparam int DIVIDEND_W     = TOTAL_W + 8;
   localparam int DIV_COUNT_W    = $clog2(DIVIDEND_W + 1);

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CALC,
      ST_DIV,
      ST_OUT
   } flc_state_type;

   typedef struct packed {
      logic capture;
      logic fetch;
      logic calc;
      logic div_step;
      logic restart;
   } flc_cmd_type;

   typedef struct packed {
      logic last_pixel;
      logic div_done;
   } flc_status_type;

   // Absolute difference between a pixel and the truncated mean of the
   // neighbors that exist. A division by three is a multiply by 683/2048,
   // which is exact for sums up to 1020.
   function automatic logic [PIXEL_W-1:0] contrast(
      input logic [PIXEL_W-1:0] centre,
      input logic hu, input logic [PIXEL_W-1:0] u,
      input logic hd, input logic [PIXEL_W-1:0] d,
      input logic hl, input logic [PIXEL_W-1:0] l,
      input logic hr, input logic [PIXEL_W-1:0] r);
      logic [9:0]          sum;
      logic [2:0]          cnt;
      logic [19:0]         prod;
      logic [PIXEL_W-1:0]  avg;
      sum  = (hu ? 10'(u) : 10'd0) + (hd ? 10'(d) : 10'd0)
           + (hl ? 10'(l) : 10'd0) + (hr ? 10'(r) : 10'd0);
      cnt  = 3'(hu) + 3'(hd) + 3'(hl) + 3'(hr);
      prod = 20'(sum) * 20'd683;
      case (cnt)
         3'd1:    avg = sum[7:0];
         3'd2:    avg = sum[8:1];
         3'd3:    avg = prod[18:11];
         3'd4:    avg = sum[9:2];
         default: avg = centre;
      endcase
      return (avg > centre) ? (avg - centre) : (centre - avg);
   endfunction

endpackage

>>> hw/rtl/frame_local_contrast.sv
// Top level of the frame local contrast block: controller plus datapath.
// Depends on flc_pkg, flc_ctrl, flc_datapath.
//
// Pixels arrive in raster order; each one goes through accept, line store read
// of the column, read of the next column and accumulate, since the middle line
// store has one read port and is read at two columns per pixel; the next pixel
// is not taken until the accumulate is done. The frame's last pixel then runs a
// restoring divider, one quotient bit per cycle: 39 steps, then a check that
// the count has run out, before the result transaction is shown; no pixel is
// taken until that result is taken. A configuration write restarts the frame,
// and the line stores need no clearing after reset.
module frame_local_contrast #(
   parameter int MAX_WIDTH  = flc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = flc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [flc_pkg::PIXEL_W-1:0]     req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [flc_pkg::TOTAL_W-1:0]     rsp_contrast_total,
   output logic [flc_pkg::MEAN_W-1:0]      rsp_mean_contrast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [flc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [flc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import flc_pkg::*;

   flc_cmd_type    cmd;
   flc_status_type status;

   assign csr_ready = 1'b1;

   flc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   flc_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_pixel          (req_pixel),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_contrast_total (rsp_contrast_total),
      .rsp_mean_contrast  (rsp_mean_contrast)
   );

`ifndef SYNTH
   // No pixel is taken while a result waits.
   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("pixel accepted while a result is pending");

   // A taken result is not shown again.
   a_result_once: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result repeated");

   // A zero total gives a zero mean.
   a_zero_mean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_contrast_total == '0) |-> (rsp_mean_contrast == '0))
      else $error("mean inconsistent with total");
`endif

endmodule

>>> hw/rtl/flc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module flc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/flc_ctrl.sv
// Controller state machine for the frame local contrast block.
// Depends on flc_pkg.
module flc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  flc_pkg::flc_status_type status,
   output flc_pkg::flc_cmd_type    cmd
);
   import flc_pkg::*;

   flc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = status.last_pixel ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_OUT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.restart = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/flc_datapath.sv
// Datapath of the frame local contrast block: registers, line stores, pixel
// window, accumulator and the restoring divider. Depends on flc_pkg, flc_ram.
module flc_datapath #(
   parameter int MAX_WIDTH  = flc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = flc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  flc_pkg::flc_cmd_type              cmd,
   output flc_pkg::flc_status_type           status,
   input  logic [flc_pkg::PIXEL_W-1:0]       req_pixel,
   input  logic                              csr_write,
   input  logic [flc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [flc_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic [flc_pkg::TOTAL_W-1:0]       rsp_contrast_total,
   output logic [flc_pkg::MEAN_W-1:0]        rsp_mean_contrast
);
   import flc_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int NW = CW + RW + 2;

   logic [CFG_WIDTH_W-1:0]  width_cfg_ff;
   logic [CFG_HEIGHT_W-1:0] height_cfg_ff;
   logic [CW-1:0]           col_ff;
   logic [RW-1:0]           row_ff;
   logic [TOTAL_W-1:0]      acc_ff, acc_in;
   logic [PIXEL_W-1:0]      pix_ff, midc_ff, upc_ff;
   logic [PIXEL_W-1:0]      win0_ff, win1_ff, win2_ff;
   logic [DIVIDEND_W-1:0]   quo_ff;
   logic [NW-1:0]           rem_ff;
   logic [DIV_COUNT_W-1:0]  cnt_ff;

   logic [CW:0]             weff;
   logic [RW:0]             heff;
   logic [CW:0]             col_next;
   logic [NW-1:0]           pix_count;
   logic                    last_row, last_col, has_right, last_pixel;
   logic                    row_ge1, row_ge2, col_ge1, col_ge2;
   logic [PIXEL_W-1:0]      mid_rdata, up_rdata;
   logic [CW-1:0]           mid_raddr;
   logic [PIXEL_W-1:0]      con_a, con_b, con_c;
   logic [NW:0]             trial;
   logic                    trial_ge;

   // Zero sizes count as one; sizes above the store depth saturate.
   always_comb begin
      if (width_cfg_ff == '0) begin
         weff = (CW+1)'(1);
      end else if (32'(width_cfg_ff) > MAX_WIDTH) begin
         weff = (CW+1)'(MAX_WIDTH);
      end else begin
         weff = (CW+1)'(width_cfg_ff);
      end
      if (height_cfg_ff == '0) begin
         heff = (RW+1)'(1);
      end else if (32'(height_cfg_ff) > MAX_HEIGHT) begin
         heff = (RW+1)'(MAX_HEIGHT);
      end else begin
         heff = (RW+1)'(height_cfg_ff);
      end
   end

   assign col_next   = {1'b0, col_ff} + (CW+1)'(1);
   assign last_col   = ({1'b0, col_ff} == weff - (CW+1)'(1));
   assign last_row   = ({1'b0, row_ff} == heff - (RW+1)'(1));
   assign has_right  = (col_next < weff);
   assign last_pixel = last_row && last_col;
   assign row_ge1    = (row_ff != '0);
   assign row_ge2    = row_ge1 && (row_ff != RW'(1));
   assign col_ge1    = (col_ff != '0);
   assign col_ge2    = col_ge1 && (col_ff != CW'(1));
   assign pix_count  = NW'(weff) * NW'(heff);

   assign mid_raddr = cmd.fetch ? col_next[CW-1:0] : col_ff;

   flc_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
      .clock   (clock),
      .wr_en   (cmd.calc),
      .wr_addr (col_ff),
      .wr_data (pix_ff),
      .rd_addr (mid_raddr),
      .rd_data (mid_rdata)
   );

   flc_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_up_ram (
      .clock   (clock),
      .wr_en   (cmd.calc && row_ge1),
      .wr_addr (col_ff),
      .wr_data (midc_ff),
      .rd_addr (col_ff),
      .rd_data (up_rdata)
   );

   // In the calc cycle the middle store's read data is the right neighbor
   // of the pixel one row up.
   always_comb begin
      con_a = '0;
      con_b = '0;
      con_c = '0;
      if (row_ge1) begin
         con_a = contrast(midc_ff, row_ge2, upc_ff, 1'b1, pix_ff,
                          col_ge1, win0_ff, has_right, mid_rdata);
      end
      if (last_row && col_ge1) begin
         con_b = contrast(win1_ff, row_ge1, win0_ff, 1'b0, '0,
                          col_ge2, win2_ff, 1'b1, pix_ff);
      end
      if (last_pixel) begin
         con_c = contrast(pix_ff, row_ge1, midc_ff, 1'b0, '0,
                          col_ge1, win1_ff, 1'b0, '0);
      end
      acc_in = acc_ff + TOTAL_W'(con_a) + TOTAL_W'(con_b) + TOTAL_W'(con_c);
   end

   assign trial    = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign trial_ge = (trial >= {1'b0, pix_count});

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= CFG_WIDTH_W'(RESET_WIDTH);
         height_cfg_ff <= CFG_HEIGHT_W'(RESET_HEIGHT);
         col_ff        <= '0;
         row_ff        <= '0;
         acc_ff        <= '0;
         cnt_ff        <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_FRAME_WIDTH: begin
                  width_cfg_ff <= csr_data[CFG_WIDTH_W-1:0];
                  col_ff       <= '0;
                  row_ff       <= '0;
                  acc_ff       <= '0;
               end
               REG_FRAME_HEIGHT: begin
                  height_cfg_ff <= csr_data[CFG_HEIGHT_W-1:0];
                  col_ff        <= '0;
                  row_ff        <= '0;
                  acc_ff        <= '0;
               end
               default: begin
               end
            endcase
         end else if (cmd.calc) begin
            acc_ff <= acc_in;
            if (last_pixel) begin
               cnt_ff <= DIV_COUNT_W'(DIVIDEND_W);
            end else if (last_col) begin
               col_ff <= '0;
               row_ff <= row_ff + RW'(1);
            end else begin
               col_ff <= col_next[CW-1:0];
            end
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff - DIV_COUNT_W'(1);
         end else if (cmd.restart) begin
            col_ff <= '0;
            row_ff <= '0;
            acc_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pix_ff <= req_pixel;
      end
      if (cmd.fetch) begin
         midc_ff <= mid_rdata;
         upc_ff  <= up_rdata;
      end
      if (cmd.calc) begin
         win0_ff <= midc_ff;
         win1_ff <= pix_ff;
         win2_ff <= win1_ff;
         quo_ff  <= {acc_in, 8'd0};
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? NW'(trial - {1'b0, pix_count}) : trial[NW-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], trial_ge};
      end
   end

   assign status.last_pixel = last_pixel;
   assign status.div_done   = (cnt_ff == '0);

   assign rsp_contrast_total = acc_ff;
   assign rsp_mean_contrast  = (quo_ff[DIVIDEND_W-1:MEAN_W] != '0) ? '1
                                                                    : quo_ff[MEAN_W-1:0];

endmodule
